// ===== rtl/dspd_pkg.sv =====
// Shared constants, types and tone tables for the DTMF spectrum peak decider.
package dspd_pkg;

  localparam int FFT_SIZE     = 2048;
  localparam int BINS_SCANNED = 1024;
  localparam int FFT_LOG2     = $clog2(FFT_SIZE);
  localparam int BIN_W        = $clog2(BINS_SCANNED);
  localparam int CNT_W        = $clog2(BINS_SCANNED + 1);
  localparam int NUM_PEAKS    = 2;

  localparam int POW_W  = 32;
  localparam int RATE_W = 17;
  localparam int TOL_W  = 10;
  localparam int HZ_W   = 16;
  localparam int PROD_W = BIN_W + RATE_W;
  localparam int KEY_W  = 4;
  localparam int ROW_W  = 2;
  localparam int COL_W  = 2;

  localparam int NUM_ROWS = 4;
  localparam int NUM_COLS = 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RATE_W;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOL   = 2'd1;

  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 17'd8000;
  localparam logic [TOL_W-1:0]  MATCH_TOL_RST   = 10'd50;

  localparam int OUT_DATA_W = 48;

  typedef logic [HZ_W-1:0] hz_t;

  localparam hz_t ROW_TONES [NUM_ROWS] = '{16'd697, 16'd770, 16'd852, 16'd941};
  localparam hz_t COL_TONES [NUM_COLS] = '{16'd1209, 16'd1336, 16'd1477};

  // What one peak cell hands to the next one down the chain.
  typedef struct packed {
    logic              take;
    logic [POW_W-1:0]  power;
    logic [BIN_W-1:0]  bin;
  } dspd_link_t;

endpackage

// ===== rtl/dspd_peak_cell.sv =====
// One slot of the sorted peak chain: holds a bin power and index.
module dspd_peak_cell import dspd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             upd,
  input  logic             start,
  input  logic [POW_W-1:0] in_power,
  input  logic [BIN_W-1:0] in_bin,
  input  logic [POW_W-1:0] init_power,
  input  logic [BIN_W-1:0] init_bin,
  input  dspd_link_t       link_in,
  output dspd_link_t       link_out,
  output logic [BIN_W-1:0] bin_nxt_o
);

  logic [POW_W-1:0] power_r, power_nxt;
  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic             beats;

  // Strictly greater, so an equal power keeps the bin seen earlier.
  assign beats = in_power > power_r;

  always_comb begin
    power_nxt = power_r;
    bin_nxt   = bin_r;
    if (upd) begin
      if (start) begin
        power_nxt = init_power;
        bin_nxt   = init_bin;
      end else if (link_in.take) begin
        // The slot above took a new word, so its old content moves down here.
        power_nxt = link_in.power;
        bin_nxt   = link_in.bin;
      end else if (beats) begin
        power_nxt = in_power;
        bin_nxt   = in_bin;
      end
    end
  end

  assign link_out.take  = link_in.take || beats;
  assign link_out.power = power_r;
  assign link_out.bin   = bin_r;
  assign bin_nxt_o      = bin_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r <= '0;
      bin_r   <= '0;
    end else begin
      power_r <= power_nxt;
      bin_r   <= bin_nxt;
    end
  end

endmodule

// ===== rtl/dspd_tone_match.sv =====
// Decision pipeline: peak bins to hertz, nearest tones, tolerance check.
module dspd_tone_match import dspd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s_valid,
  output logic                  s_ready,
  input  logic [BIN_W-1:0]      bin_a,
  input  logic [BIN_W-1:0]      bin_b,
  input  logic [RATE_W-1:0]     sample_rate,
  input  logic [TOL_W-1:0]      match_tol,
  output logic                  m_valid,
  input  logic                  m_ready,
  output logic [OUT_DATA_W-1:0] m_data
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy2, rdy3, rdy4;

  logic [BIN_W-1:0]  bin_a_r, bin_b_r;
  logic [PROD_W-1:0] lo_prod_r, hi_prod_r;
  hz_t               lo_hz_r, hi_hz_r, lo_hz4_r, hi_hz4_r;
  hz_t               row_d_r [NUM_ROWS];
  hz_t               col_d_r [NUM_COLS];
  logic              det_r;
  logic [KEY_W-1:0]  key_r;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;

  assign rdy4    = !v4_r || m_ready;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign s_ready = !v1_r || rdy2;

  // Stage 2: order the bins and scale them by the sample rate.
  logic [BIN_W-1:0] lo_bin, hi_bin;
  always_comb begin
    if (bin_a_r < bin_b_r) begin
      lo_bin = bin_a_r;
      hi_bin = bin_b_r;
    end else begin
      lo_bin = bin_b_r;
      hi_bin = bin_a_r;
    end
  end

  // Stage 3: drop the FFT size and saturate to the 16-bit field.
  logic [PROD_W-1:0] lo_sh, hi_sh;
  hz_t               lo_hz, hi_hz;
  assign lo_sh = lo_prod_r >> FFT_LOG2;
  assign hi_sh = hi_prod_r >> FFT_LOG2;
  assign lo_hz = (|lo_sh[PROD_W-1:HZ_W]) ? '1 : lo_sh[HZ_W-1:0];
  assign hi_hz = (|hi_sh[PROD_W-1:HZ_W]) ? '1 : hi_sh[HZ_W-1:0];

  hz_t row_d [NUM_ROWS];
  hz_t col_d [NUM_COLS];
  always_comb begin
    for (int i = 0; i < NUM_ROWS; i++) begin
      row_d[i] = (lo_hz > ROW_TONES[i]) ? lo_hz - ROW_TONES[i] : ROW_TONES[i] - lo_hz;
    end
    for (int j = 0; j < NUM_COLS; j++) begin
      col_d[j] = (hi_hz > COL_TONES[j]) ? hi_hz - COL_TONES[j] : COL_TONES[j] - hi_hz;
    end
  end

  // Stage 4: nearest tone in each table; the first entry wins on a tie.
  hz_t              best_rd, best_cd;
  logic [ROW_W-1:0] r_sel;
  logic [COL_W-1:0] c_sel;
  logic             ok;
  always_comb begin
    best_rd = row_d_r[0];
    r_sel   = '0;
    for (int i = 1; i < NUM_ROWS; i++) begin
      if (row_d_r[i] < best_rd) begin
        best_rd = row_d_r[i];
        r_sel   = ROW_W'(i);
      end
    end
    best_cd = col_d_r[0];
    c_sel   = '0;
    for (int j = 1; j < NUM_COLS; j++) begin
      if (col_d_r[j] < best_cd) begin
        best_cd = col_d_r[j];
        c_sel   = COL_W'(j);
      end
    end
    ok = (best_rd <= HZ_W'(match_tol)) && (best_cd <= HZ_W'(match_tol));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (s_ready) v1_r <= s_valid;
      if (rdy2)    v2_r <= v1_r;
      if (rdy3)    v3_r <= v2_r;
      if (rdy4)    v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      bin_a_r <= bin_a;
      bin_b_r <= bin_b;
    end
    if (rdy2 && v1_r) begin
      lo_prod_r <= PROD_W'(lo_bin) * PROD_W'(sample_rate);
      hi_prod_r <= PROD_W'(hi_bin) * PROD_W'(sample_rate);
    end
    if (rdy3 && v2_r) begin
      lo_hz_r <= lo_hz;
      hi_hz_r <= hi_hz;
      row_d_r <= row_d;
      col_d_r <= col_d;
    end
    if (rdy4 && v3_r) begin
      det_r    <= ok;
      key_r    <= ok ? (KEY_W'(r_sel) * KEY_W'(NUM_COLS)) + KEY_W'(c_sel) : '0;
      row_r    <= ok ? r_sel : '0;
      col_r    <= ok ? c_sel : '0;
      lo_hz4_r <= lo_hz_r;
      hi_hz4_r <= hi_hz_r;
    end
  end

  assign m_valid = v4_r;
  assign m_data  = {7'b0, hi_hz4_r, lo_hz4_r, col_r, row_r, key_r, det_r};

endmodule

// ===== rtl/dtmf_spectrum_peak_decider_core.sv =====
// Top level: bin counter, chain of peak cells, config registers, decision pipeline.
// Throughput: one bin word per cycle while in_tready is high; a frame's result follows its last bin.
// After the edge that accepts the last bin, the result moves through the peak pair, product,
// hertz/distance and output registers before out_tvalid rises.
// in_tready drops only when all four result stages hold words the sink has not taken.
// Synchronous reset clears peaks, bin counter and pipeline and loads 8000 Hz and 50 Hz.
module dtmf_spectrum_peak_decider_core import dspd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [POW_W-1:0]      in_tdata,  // bin_power
  input  logic                  in_tlast,  // last_bin
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // detected, key_code, row_index, col_index, low_peak_hz, high_peak_hz, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [RATE_W-1:0] rate_r;
  logic [TOL_W-1:0]  tol_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              accept, scanned, start, m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= SAMPLE_RATE_RST;
      tol_r  <= MATCH_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_RATE: rate_r <= cfg_wdata[RATE_W-1:0];
        REG_MATCH_TOL:   tol_r  <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = m_ready;
  assign accept    = in_tvalid && in_tready;
  assign scanned   = cnt_r < CNT_W'(BINS_SCANNED);
  assign start     = cnt_r == '0;

  // Counter holds the index of the next bin and saturates past the scanned range.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      if (in_tlast) cnt_r <= '0;
      else if (scanned) cnt_r <= cnt_r + 1'b1;
    end
  end

  dspd_link_t       link [NUM_PEAKS+1];
  logic [BIN_W-1:0] bin_nxt [NUM_PEAKS];

  assign link[0] = '{take: 1'b0, power: '0, bin: '0};

  // Cell 0 keeps the strongest bin; a frame starts as bin 0 and a zero-power bin 1.
  for (genvar k = 0; k < NUM_PEAKS; k++) begin : g_cell
    dspd_peak_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .upd        (accept && scanned),
      .start      (start),
      .in_power   (in_tdata),
      .in_bin     (cnt_r[BIN_W-1:0]),
      .init_power ((k == 0) ? in_tdata : '0),
      .init_bin   (BIN_W'(k)),
      .link_in    (link[k]),
      .link_out   (link[k+1]),
      .bin_nxt_o  (bin_nxt[k])
    );
  end

  dspd_tone_match u_match (
    .clk         (clk),
    .rst_n       (rst_n),
    .s_valid     (accept && in_tlast),
    .s_ready     (m_ready),
    .bin_a       (bin_nxt[0]),
    .bin_b       (bin_nxt[1]),
    .sample_rate (rate_r),
    .match_tol   (tol_r),
    .m_valid     (out_tvalid),
    .m_ready     (out_tready),
    .m_data      (out_tdata)
  );

endmodule
